@@ hdl/pdu_dfr_pkg.sv @@
`default_nettype none

package pdu_dfr_pkg;

    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_HEAD = 2'd1,
        PH_BODY = 2'd2
    } phase_t;

    typedef logic [1:0] err_t;

    localparam err_t ERR_NONE   = 2'd0;
    localparam err_t ERR_CODE   = 2'd1;
    localparam err_t ERR_LENGTH = 2'd2;

    typedef logic [2:0] reg_idx_t;

    localparam reg_idx_t REG_IS_RESPONSE  = 3'd0;
    localparam reg_idx_t REG_CODE_WR_MEM  = 3'd1;
    localparam reg_idx_t REG_CODE_RD_CFG  = 3'd2;
    localparam reg_idx_t REG_CODE_SET_CMD = 3'd3;
    localparam reg_idx_t REG_MAX_LENGTH   = 3'd4;

    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    localparam logic [6:0] RST_CODE_WR_MEM  = 7'd16;
    localparam logic [6:0] RST_CODE_RD_CFG  = 7'd3;
    localparam logic [6:0] RST_CODE_SET_CMD = 7'd6;
    localparam logic [7:0] RST_MAX_LENGTH   = 8'd252;

    // Length base of each PDU kind; the count byte sits at base - 1.
    localparam logic [2:0] BASE_NONE   = 3'd0;
    localparam logic [2:0] BASE_SHORT  = 3'd1;
    localparam logic [2:0] BASE_RD_CFG = 3'd4;
    localparam logic [2:0] BASE_WR_MEM = 3'd6;

endpackage

`default_nettype wire

@@ hdl/bus_pdu_length_deframer_unit.sv @@
`default_nettype none

// Channel  | Direction | Handshake             | Payload
// ---------+-----------+-----------------------+-----------------------------------------
// input    | in        | in_valid / in_ready   | data_byte
// output   | out       | out_valid / out_ready | out_byte, is_code_byte, function_code,
//          |           |                       | is_exception, end_of_pdu, error_kind
// config   | in        | APB, pready tied high | five registers at paddr 0, 4, 8, 12, 16
//
// One byte per cycle: the parse state and the result register both load at the
// accepting edge, so the result appears in the cycle after the byte is taken.
// in_ready drops only while a result is held and out_ready is low.
// Reset returns the parser to waiting for a code byte and loads register defaults.
module bus_pdu_length_deframer_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [7:0]                    data_byte,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [7:0]                         out_byte,
    output logic                               is_code_byte,
    output logic [6:0]                         function_code,
    output logic                               is_exception,
    output logic                               end_of_pdu,
    output logic [1:0]                         error_kind,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [pdu_dfr_pkg::ADDR_W-1:0] paddr,
    input  wire logic [pdu_dfr_pkg::DATA_W-1:0] pwdata,
    output logic [pdu_dfr_pkg::DATA_W-1:0]      prdata,
    output logic                               pready
);
    import pdu_dfr_pkg::*;

    logic       is_response_reg;
    logic [6:0] code_wr_mem_reg;
    logic [6:0] code_rd_cfg_reg;
    logic [6:0] code_set_cmd_reg;
    logic [7:0] max_length_reg;

    phase_t     phase_reg,     phase_next;
    logic [7:0] data_index_reg, data_index_next;
    logic [8:0] exp_len_reg,   exp_len_next;
    logic [6:0] cur_code_reg,  cur_code_next;
    logic       exc_mark_reg,  exc_mark_next;

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       code_flag_reg, code_flag_next;
    logic [6:0] func_code_reg;
    logic       is_exc_reg;
    logic       end_reg,       end_next;
    err_t       err_reg,       err_next;

    logic       accept;
    logic       cfg_write;
    reg_idx_t   reg_idx;
    logic [2:0] base;
    logic [8:0] idx_inc;
    logic [9:0] hdr_len;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_response_reg  <= 1'b0;
            code_wr_mem_reg  <= RST_CODE_WR_MEM;
            code_rd_cfg_reg  <= RST_CODE_RD_CFG;
            code_set_cmd_reg <= RST_CODE_SET_CMD;
            max_length_reg   <= RST_MAX_LENGTH;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_IS_RESPONSE:  is_response_reg  <= pwdata[0];
                REG_CODE_WR_MEM:  code_wr_mem_reg  <= pwdata[6:0];
                REG_CODE_RD_CFG:  code_rd_cfg_reg  <= pwdata[6:0];
                REG_CODE_SET_CMD: code_set_cmd_reg <= pwdata[6:0];
                REG_MAX_LENGTH:   max_length_reg   <= pwdata[7:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_IS_RESPONSE:  prdata = {{(DATA_W-1){1'b0}}, is_response_reg};
            REG_CODE_WR_MEM:  prdata = {{(DATA_W-7){1'b0}}, code_wr_mem_reg};
            REG_CODE_RD_CFG:  prdata = {{(DATA_W-7){1'b0}}, code_rd_cfg_reg};
            REG_CODE_SET_CMD: prdata = {{(DATA_W-7){1'b0}}, code_set_cmd_reg};
            REG_MAX_LENGTH:   prdata = {{(DATA_W-8){1'b0}}, max_length_reg};
            default:          prdata = '0;
        endcase
    end

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Write memory beats read config, which beats set command.
    always_comb
    begin
        if (data_byte[6:0] == code_wr_mem_reg)
            base = is_response_reg ? BASE_SHORT : BASE_WR_MEM;
        else if (data_byte[6:0] == code_rd_cfg_reg)
            base = is_response_reg ? BASE_SHORT : BASE_RD_CFG;
        else if (data_byte[6:0] == code_set_cmd_reg)
            base = BASE_SHORT;
        else
            base = BASE_NONE;
    end

    assign idx_inc = {1'b0, data_index_reg} + 9'd1;
    assign hdr_len = {1'b0, exp_len_reg} + {2'b00, data_byte};

    always_comb
    begin
        phase_next      = phase_reg;
        data_index_next = data_index_reg;
        exp_len_next    = exp_len_reg;
        cur_code_next   = cur_code_reg;
        exc_mark_next   = exc_mark_reg;
        code_flag_next  = 1'b0;
        end_next        = 1'b0;
        err_next        = ERR_NONE;
        unique case (phase_reg)
            PH_HEAD:
            begin
                if (idx_inc >= exp_len_reg)
                begin
                    // count byte: the data length is known now
                    if (hdr_len > {2'b00, max_length_reg})
                    begin
                        end_next   = 1'b1;
                        err_next   = ERR_LENGTH;
                        phase_next = PH_WAIT;
                    end
                    else if ({1'b0, idx_inc} >= hdr_len)
                    begin
                        end_next   = 1'b1;
                        phase_next = PH_WAIT;
                    end
                    else
                    begin
                        exp_len_next    = hdr_len[8:0];
                        data_index_next = idx_inc[7:0];
                        phase_next      = PH_BODY;
                    end
                end
                else
                begin
                    data_index_next = idx_inc[7:0];
                end
            end
            PH_BODY:
            begin
                if (idx_inc >= exp_len_reg)
                begin
                    end_next   = 1'b1;
                    phase_next = PH_WAIT;
                end
                else
                begin
                    data_index_next = idx_inc[7:0];
                end
            end
            default:
            begin
                code_flag_next  = 1'b1;
                cur_code_next   = data_byte[6:0];
                exc_mark_next   = data_byte[7];
                data_index_next = '0;
                if (data_byte[7])
                begin
                    if (max_length_reg == '0)
                    begin
                        end_next   = 1'b1;
                        err_next   = ERR_LENGTH;
                        phase_next = PH_WAIT;
                    end
                    else
                    begin
                        exp_len_next = 9'd1;
                        phase_next   = PH_BODY;
                    end
                end
                else if (base == BASE_NONE)
                begin
                    end_next   = 1'b1;
                    err_next   = ERR_CODE;
                    phase_next = PH_WAIT;
                end
                else
                begin
                    exp_len_next = {6'd0, base};
                    phase_next   = PH_HEAD;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_WAIT;
            data_index_reg <= '0;
            exp_len_reg    <= '0;
            cur_code_reg   <= '0;
            exc_mark_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg      <= phase_next;
                data_index_reg <= data_index_next;
                exp_len_reg    <= exp_len_next;
                cur_code_reg   <= cur_code_next;
                exc_mark_reg   <= exc_mark_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Load the result beat only on accept; hold it otherwise.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_byte_reg  <= data_byte;
            code_flag_reg <= code_flag_next;
            func_code_reg <= cur_code_next;
            is_exc_reg    <= exc_mark_next;
            end_reg       <= end_next;
            err_reg       <= err_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign is_code_byte  = code_flag_reg;
    assign function_code = func_code_reg;
    assign is_exception  = is_exc_reg;
    assign end_of_pdu    = end_reg;
    assign error_kind    = err_reg;

    a_err_ends_pdu: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (err_reg != ERR_NONE) |-> end_reg)
        else $error("error reported without end of PDU");

    a_code_err_on_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (err_reg == ERR_CODE) |-> code_flag_reg)
        else $error("undefined code error on a non-code byte");

    a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (err_reg == ERR_NONE || err_reg == ERR_CODE
                           || err_reg == ERR_LENGTH))
        else $error("error kind out of range");

    a_body_index: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BODY) |-> ({1'b0, data_index_reg} < exp_len_reg))
        else $error("data index ran past the expected length");

    a_wait_takes_code: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (phase_reg == PH_WAIT) |=> out_valid_reg && code_flag_reg)
        else $error("byte taken while waiting was not marked as code byte");

endmodule

`default_nettype wire
